>>> design/cpbd_pkg.sv
// Shared types, constants and helper functions of the code point to byte decoder.
package cpbd_pkg;

    localparam int CP_W      = 21;
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 12;
    localparam int BYTE_W    = 8;
    localparam int ASCII_W   = 7;
    localparam int RUN_W     = 12;

    typedef logic [CP_W-1:0] t_cp;
    typedef logic [CP_W:0]   t_diff;

    localparam t_cp NEWLINE_CP = t_cp'(10);

    localparam logic [REG_IDX_W-1:0] REG_BYTE_BASE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDE_BASE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAIR_00   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAIR_01   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAIR_10   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PAIR_11   = 3'd5;

    localparam t_cp RST_BYTE_BASE = t_cp'(1024);
    localparam t_cp RST_WIDE_BASE = t_cp'(19968);
    localparam t_cp RST_PAIR_00   = t_cp'(24064);
    localparam t_cp RST_PAIR_01   = t_cp'(28160);
    localparam t_cp RST_PAIR_10   = t_cp'(32256);
    localparam t_cp RST_PAIR_11   = t_cp'(36352);

    typedef enum logic [1:0] {
        KIND_BYTES = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_FIN   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef struct packed {
        t_cp           byte_base;
        t_cp           wide_base;
        t_cp [3:0]     pair_base;
    } t_cfg;

    typedef struct packed {
        logic                eos;
        logic                newline;
        logic                pair_hit;
        logic [ASCII_W-1:0]  pair_a;
        logic [ASCII_W-1:0]  pair_b;
        logic                byte_hit;
        logic [BYTE_W-1:0]   byte_off;
        logic                wide_hit;
        logic [WIDE_W-1:0]   wide_off;
        t_cp                 code_point;
    } t_cls;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   byte_a;
        logic [BYTE_W-1:0]   byte_b;
        logic [BYTE_W-1:0]   byte_c;
        logic [1:0]          byte_count;
        logic [RUN_W-1:0]    run_length;
    } t_res;

    function automatic t_diff blk_diff(input t_cp u, input t_cp base);
        blk_diff = {1'b0, u} - {1'b0, base};
    endfunction

    function automatic logic in_wide(input t_diff d);
        in_wide = (d[CP_W:WIDE_W] == '0);
    endfunction

    function automatic logic in_byte(input t_diff d);
        in_byte = (d[CP_W:BYTE_W] == '0);
    endfunction

endpackage

>>> design/cpbd_req_if.sv
// Request channel interface carrying one code point per request.
interface cpbd_req_if
    import cpbd_pkg::*;
();
    logic valid;
    logic ready;
    t_cp  code_point;
    logic end_of_stream;

    modport source (output valid, output code_point, output end_of_stream, input ready);
    modport sink   (input valid, input code_point, input end_of_stream, output ready);
endinterface

>>> design/cpbd_res_if.sv
// Result channel interface carrying the decoded results, at most one per request.
interface cpbd_res_if
    import cpbd_pkg::*;
();
    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [BYTE_W-1:0]  byte_a;
    logic [BYTE_W-1:0]  byte_b;
    logic [BYTE_W-1:0]  byte_c;
    logic [1:0]         byte_count;
    logic [RUN_W-1:0]   run_length;

    modport source (output valid, output kind, output byte_a, output byte_b, output byte_c,
                    output byte_count, output run_length, input ready);
    modport sink   (input valid, input kind, input byte_a, input byte_b, input byte_c,
                    input byte_count, input run_length, output ready);
endinterface

>>> design/cpbd_regs.sv
// APB configuration register file holding the six block base addresses.
module cpbd_regs
    import cpbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_base    <= RST_BYTE_BASE;
            r_cfg.wide_base    <= RST_WIDE_BASE;
            r_cfg.pair_base[0] <= RST_PAIR_00;
            r_cfg.pair_base[1] <= RST_PAIR_01;
            r_cfg.pair_base[2] <= RST_PAIR_10;
            r_cfg.pair_base[3] <= RST_PAIR_11;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BYTE_BASE: r_cfg.byte_base    <= pwdata[CP_W-1:0];
                REG_WIDE_BASE: r_cfg.wide_base    <= pwdata[CP_W-1:0];
                REG_PAIR_00:   r_cfg.pair_base[0] <= pwdata[CP_W-1:0];
                REG_PAIR_01:   r_cfg.pair_base[1] <= pwdata[CP_W-1:0];
                REG_PAIR_10:   r_cfg.pair_base[2] <= pwdata[CP_W-1:0];
                REG_PAIR_11:   r_cfg.pair_base[3] <= pwdata[CP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BYTE_BASE: prdata = DATA_W'(r_cfg.byte_base);
            REG_WIDE_BASE: prdata = DATA_W'(r_cfg.wide_base);
            REG_PAIR_00:   prdata = DATA_W'(r_cfg.pair_base[0]);
            REG_PAIR_01:   prdata = DATA_W'(r_cfg.pair_base[1]);
            REG_PAIR_10:   prdata = DATA_W'(r_cfg.pair_base[2]);
            REG_PAIR_11:   prdata = DATA_W'(r_cfg.pair_base[3]);
            default:       prdata = '0;
        endcase
    end

endmodule

>>> design/cpbd_front.sv
// Front stage: accepts requests and classifies each code point against the blocks.
module cpbd_front
    import cpbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpbd_req_if.sink   i_req,
    input  t_cfg       i_cfg,
    input  logic       i_q_ready,
    output logic       o_q_push,
    output t_cls       o_q_data
);

    logic  r_valid;
    t_cls  r_cls;
    t_cls  n_cls;

    assign i_req.ready = !r_valid || i_q_ready;
    assign o_q_push    = r_valid && i_q_ready;
    assign o_q_data    = r_cls;

    always_comb begin
        t_diff d;
        t_diff db;
        t_diff dw;
        logic [1:0] blk;
        n_cls            = '0;
        n_cls.eos        = i_req.end_of_stream;
        n_cls.newline    = (i_req.code_point == NEWLINE_CP);
        n_cls.code_point = i_req.code_point;
        // The lowest numbered matching pair block wins.
        for (int k = 3; k >= 0; k--) begin
            d   = blk_diff(i_req.code_point, i_cfg.pair_base[k]);
            blk = 2'(k);
            if (in_wide(d)) begin
                n_cls.pair_hit = 1'b1;
                n_cls.pair_a   = {blk[1], d[11:6]};
                n_cls.pair_b   = {blk[0], i_req.code_point[5:0]};
            end
        end
        db             = blk_diff(i_req.code_point, i_cfg.byte_base);
        dw             = blk_diff(i_req.code_point, i_cfg.wide_base);
        n_cls.byte_hit = in_byte(db);
        n_cls.byte_off = db[BYTE_W-1:0];
        n_cls.wide_hit = in_wide(dw);
        n_cls.wide_off = dw[WIDE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

>>> design/cpbd_queue.sv
// Two-entry queue that decouples classification from decoding.
module cpbd_queue
    import cpbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> design/cpbd_back.sv
// Back stage: pairs held symbols, builds results and drives the result register.
module cpbd_back
    import cpbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_cls       i_q_data,
    output logic       o_q_pop,
    cpbd_res_if.source o_res
);

    logic r_out_valid;
    t_res r_res;
    t_cp  r_sym;
    logic r_pend;
    logic r_halted;

    t_res n_res;
    logic n_emit;
    t_cp  n_sym;
    logic n_pend;
    logic n_halted;

    t_diff d1b;
    t_diff d1w;
    logic  b1;
    logic  w1;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_res.ready);

    assign d1b = blk_diff(r_sym, i_cfg.byte_base);
    assign d1w = blk_diff(r_sym, i_cfg.wide_base);
    assign b1  = in_byte(d1b);
    assign w1  = in_wide(d1w);

    always_comb begin
        t_cls c;
        c        = i_q_data;
        n_res    = '0;
        n_emit   = 1'b0;
        n_sym    = r_sym;
        n_pend   = r_pend;
        n_halted = r_halted;
        if (!r_halted) begin
            if (c.eos) begin
                n_emit = 1'b1;
                n_pend = 1'b0;
                if (!r_pend) begin
                    n_res.kind = KIND_FIN;
                    n_halted   = 1'b1;
                end else if (b1) begin
                    n_res.kind       = KIND_BYTES;
                    n_res.byte_a     = d1b[BYTE_W-1:0];
                    n_res.byte_count = 2'd1;
                end else begin
                    n_res.kind = KIND_ERR;
                    n_halted   = 1'b1;
                end
            end else if (c.newline) begin
                n_emit = 1'b0;
            end else if (!r_pend) begin
                if (c.pair_hit) begin
                    n_emit           = 1'b1;
                    n_res.kind       = KIND_BYTES;
                    n_res.byte_a     = BYTE_W'(c.pair_a);
                    n_res.byte_b     = BYTE_W'(c.pair_b);
                    n_res.byte_count = 2'd2;
                end else if (c.byte_hit || c.wide_hit) begin
                    n_pend = 1'b1;
                    n_sym  = c.code_point;
                end else begin
                    n_emit     = 1'b1;
                    n_res.kind = KIND_ERR;
                    n_halted   = 1'b1;
                end
            end else begin
                n_emit = 1'b1;
                n_pend = 1'b0;
                if (w1 && c.wide_hit) begin
                    n_res.kind       = KIND_BYTES;
                    n_res.byte_a     = d1w[11:4];
                    n_res.byte_b     = {d1w[3:0], c.wide_off[11:8]};
                    n_res.byte_c     = c.wide_off[7:0];
                    n_res.byte_count = 2'd3;
                end else if (b1 && c.wide_hit) begin
                    n_res.kind       = KIND_RUN;
                    n_res.byte_a     = d1b[BYTE_W-1:0];
                    n_res.run_length = c.wide_off;
                end else if (b1 && c.byte_hit) begin
                    n_res.kind       = KIND_BYTES;
                    n_res.byte_a     = d1b[BYTE_W-1:0];
                    n_res.byte_b     = c.byte_off;
                    n_res.byte_count = 2'd2;
                end else begin
                    n_res.kind = KIND_ERR;
                    n_halted   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_halted    <= 1'b0;
            r_sym       <= '0;
        end else begin
            if (o_q_pop) begin
                r_out_valid <= n_emit;
                r_pend      <= n_pend;
                r_halted    <= n_halted;
                r_sym       <= n_sym;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_res.kind;
    assign o_res.byte_a     = r_res.byte_a;
    assign o_res.byte_b     = r_res.byte_b;
    assign o_res.byte_c     = r_res.byte_c;
    assign o_res.byte_count = r_res.byte_count;
    assign o_res.run_length = r_res.run_length;

endmodule

>>> design/codepoint_to_byte_decoder_core.sv
// Top level of the code point to byte decoder.
// The decoder takes one code point request per cycle while the result side is ready;
// a stall there backs up through the queue into the request side. A classification
// register, a two-entry queue and a result register stand between the two channels.
// Newlines and the first symbol of a pair give no result. The six block bases are
// written over the APB port at byte addresses 0, 4, 8, 12, 16 and 20; the user must
// write them only while the decoder is idle, which the block itself does not enforce.
// After a finish or an error result the decoder ignores all requests until reset.
module codepoint_to_byte_decoder_core
    import cpbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpbd_req_if.sink          i_req,
    cpbd_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    logic q_push;
    t_cls q_wdata;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_cls q_rdata;

    cpbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cfg     (cfg),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    cpbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    cpbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

>>> design/cpbd_checker.sv
// Port-level checker for the decoder top level and its bind statement.
module cpbd_checker
    import cpbd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input t_kind             res_kind,
    input logic [BYTE_W-1:0] res_byte_a,
    input logic [1:0]        res_byte_count,
    input logic [RUN_W-1:0]  res_run_length,
    input logic              pready
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind))
        else $error("stalled result dropped or changed");

    a_bytes_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_kind == KIND_BYTES |-> res_byte_count != 2'd0 && res_run_length == '0)
        else $error("byte result with bad count or run length");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && (res_kind == KIND_FIN || res_kind == KIND_ERR)
            |-> res_byte_a == '0 && res_byte_count == 2'd0 && res_run_length == '0)
        else $error("finish or error result carries data");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind codepoint_to_byte_decoder_core cpbd_checker u_cpbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .res_valid      (o_res.valid),
    .res_ready      (o_res.ready),
    .res_kind       (o_res.kind),
    .res_byte_a     (o_res.byte_a),
    .res_byte_count (o_res.byte_count),
    .res_run_length (o_res.run_length),
    .pready         (pready)
);

>>> tb/codepoint_to_byte_decoder_core_test.sv
// Self-checking testbench for the code point to byte decoder, with a scoreboard class.
`timescale 1ns / 100ps

module codepoint_to_byte_decoder_core_test;
    import cpbd_pkg::*;

    localparam int  BYTE_SPAN   = 256;
    localparam int  WIDE_SPAN   = 4096;
    localparam int  PAIR_SPAN   = 4096;
    localparam int  CYCLE_LIMIT = 400000;
    localparam t_cp TOP_BASE    = t_cp'(1110016);

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cpbd_req_if req_ch();
    cpbd_res_if res_ch();

    class decoded_byte_ledger;
        t_cp  base [NUM_REGS];
        t_cp  held_cp;
        bit   held;
        bit   stopped;
        int   failures;
        t_res owed [$];

        function new();
            base[REG_BYTE_BASE] = RST_BYTE_BASE;
            base[REG_WIDE_BASE] = RST_WIDE_BASE;
            base[REG_PAIR_00]   = RST_PAIR_00;
            base[REG_PAIR_01]   = RST_PAIR_01;
            base[REG_PAIR_10]   = RST_PAIR_10;
            base[REG_PAIR_11]   = RST_PAIR_11;
            held_cp  = '0;
            held     = 1'b0;
            stopped  = 1'b0;
            failures = 0;
        endfunction

        function bit in_blk(t_cp u, t_cp start, int unsigned span);
            int unsigned uu;
            int unsigned ss;
            uu = 32'(u);
            ss = 32'(start);
            return (uu >= ss) && (uu < ss + span);
        endfunction

        function bit decode(input t_cp cp, input logic eos, inout t_cp hcp, inout bit hv,
                            inout bit hs, output t_res r);
            t_cp bb;
            t_cp wb;
            t_cp first;
            t_cp d1;
            t_cp d2;
            bit  w1;
            bit  w2;
            bit  b1;
            bit  b2;
            r  = '0;
            bb = base[REG_BYTE_BASE];
            wb = base[REG_WIDE_BASE];
            if (hs) begin
                return 1'b0;
            end
            if (eos) begin
                if (!hv) begin
                    hs     = 1'b1;
                    r.kind = KIND_FIN;
                    return 1'b1;
                end
                first = hcp;
                hv    = 1'b0;
                hcp   = '0;
                if (in_blk(first, bb, BYTE_SPAN)) begin
                    d1           = first - bb;
                    r.byte_a     = d1[7:0];
                    r.byte_count = 2'd1;
                    return 1'b1;
                end
                hs     = 1'b1;
                r.kind = KIND_ERR;
                return 1'b1;
            end
            if (cp == NEWLINE_CP) begin
                return 1'b0;
            end
            if (!hv) begin
                for (int k = 0; k < 4; k++) begin
                    if (in_blk(cp, base[REG_PAIR_00 + k], PAIR_SPAN)) begin
                        d1           = cp - base[REG_PAIR_00 + k];
                        r.byte_a     = {2'b00, d1[11:6]} + ((k >= 2) ? 8'd64 : 8'd0);
                        r.byte_b     = {2'b00, cp[5:0]} + ((k % 2 == 1) ? 8'd64 : 8'd0);
                        r.byte_count = 2'd2;
                        return 1'b1;
                    end
                end
                if (in_blk(cp, bb, BYTE_SPAN) || in_blk(cp, wb, WIDE_SPAN)) begin
                    hcp = cp;
                    hv  = 1'b1;
                    return 1'b0;
                end
                hs     = 1'b1;
                r.kind = KIND_ERR;
                return 1'b1;
            end
            first = hcp;
            hv    = 1'b0;
            hcp   = '0;
            w1    = in_blk(first, wb, WIDE_SPAN);
            w2    = in_blk(cp, wb, WIDE_SPAN);
            b1    = in_blk(first, bb, BYTE_SPAN);
            b2    = in_blk(cp, bb, BYTE_SPAN);
            d1    = first - wb;
            d2    = cp - wb;
            if (w1 && w2) begin
                r.byte_a     = d1[11:4];
                r.byte_b     = {d1[3:0], d2[11:8]};
                r.byte_c     = d2[7:0];
                r.byte_count = 2'd3;
                return 1'b1;
            end
            if (b1 && w2) begin
                d1           = first - bb;
                r.kind       = KIND_RUN;
                r.byte_a     = d1[7:0];
                r.run_length = d2[11:0];
                return 1'b1;
            end
            if (b1 && b2) begin
                d1           = first - bb;
                d2           = cp - bb;
                r.byte_a     = d1[7:0];
                r.byte_b     = d2[7:0];
                r.byte_count = 2'd2;
                return 1'b1;
            end
            hs     = 1'b1;
            r.kind = KIND_ERR;
            return 1'b1;
        endfunction

        function bit would_halt(t_cp cp, logic eos);
            t_cp  c;
            bit   v;
            bit   s;
            t_res r;
            c = held_cp;
            v = held;
            s = stopped;
            void'(decode(cp, eos, c, v, s, r));
            return s && !stopped;
        endfunction

        function void note_code_point(t_cp cp, logic eos);
            t_res r;
            if (decode(cp, eos, held_cp, held, stopped, r)) begin
                owed.push_back(r);
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_decoded(t_res got);
            t_res want;
            if (owed.size() == 0) begin
                $error("result with no request owing one: kind %0d", got.kind);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("byte_a", want.byte_a, got.byte_a);
            compare_field("byte_b", want.byte_b, got.byte_b);
            compare_field("byte_c", want.byte_c, got.byte_c);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("run_length", want.run_length, got.run_length);
        endfunction
    endclass

    decoded_byte_ledger board = new();
    int burst_left;

    codepoint_to_byte_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int mode;
        int stall;
        int cyc;
        t_res got;
        mode  = 0;
        stall = 0;
        cyc   = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.kind       = res_ch.kind;
                got.byte_a     = res_ch.byte_a;
                got.byte_b     = res_ch.byte_b;
                got.byte_c     = res_ch.byte_c;
                got.byte_count = res_ch.byte_count;
                got.run_length = res_ch.run_length;
                board.check_decoded(got);
            end
            cyc++;
            if (cyc % 256 == 0) begin
                mode = $urandom_range(0, 2);
            end
            if (stall > 0) begin
                stall--;
                res_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall = $urandom_range(4, 30);
                        end
                        res_ch.ready <= (stall == 0);
                    end
                endcase
            end
        end
    end

    function automatic t_cp pick_offset(int span);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return t_cp'(span - 1);
            default: return t_cp'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic push(input t_cp cp, input logic eos, input bit may_halt, output bit sent);
        int gap;
        sent = 1'b0;
        if (!may_halt && board.would_halt(cp, eos)) begin
            return;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.code_point    <= cp;
        req_ch.end_of_stream <= eos;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_code_point(cp, eos);
        sent = 1'b1;
    endtask

    task automatic send_counted(input t_cp cp, input logic eos, inout int sent);
        bit s;
        push(cp, eos, 1'b0, s);
        sent += s;
    endtask

    task automatic send_two(input t_cp first, input t_cp second, input logic second_eos,
                            inout int sent);
        send_counted(first, 1'b0, sent);
        if ($urandom_range(0, 5) == 0) begin
            send_counted(NEWLINE_CP, 1'b0, sent);
        end
        send_counted(second, second_eos, sent);
    endtask

    task automatic random_sequence(inout int sent);
        t_cp bb;
        t_cp wb;
        int  k;
        bb = board.base[REG_BYTE_BASE];
        wb = board.base[REG_WIDE_BASE];
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                k = $urandom_range(0, 3);
                send_counted(board.base[REG_PAIR_00 + k] + pick_offset(PAIR_SPAN), 1'b0, sent);
            end
            3, 4: send_two(wb + pick_offset(WIDE_SPAN), wb + pick_offset(WIDE_SPAN), 1'b0, sent);
            5, 6: send_two(bb + pick_offset(BYTE_SPAN), wb + pick_offset(WIDE_SPAN), 1'b0, sent);
            7: send_two(bb + pick_offset(BYTE_SPAN), bb + pick_offset(BYTE_SPAN), 1'b0, sent);
            8: send_two(bb + pick_offset(BYTE_SPAN), t_cp'($urandom), 1'b1, sent);
            default: send_counted(NEWLINE_CP, 1'b0, sent);
        endcase
    endtask

    task automatic run_phase(input int count);
        int  sent;
        bit  s;
        sent = 0;
        while (sent < count) random_sequence(sent);
        if (board.held) begin
            if (board.in_blk(board.held_cp, board.base[REG_BYTE_BASE], BYTE_SPAN)) begin
                push(t_cp'($urandom), 1'b1, 1'b0, s);
            end else begin
                push(board.base[REG_WIDE_BASE] + pick_offset(WIDE_SPAN), 1'b0, 1'b0, s);
            end
        end
        req_ch.valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [REG_IDX_W-1:0] idx, input t_cp value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.base[idx] = value;
    endtask

    task automatic load_bases(input t_cp bb, input t_cp wb, input t_cp p00, input t_cp p01,
                              input t_cp p10, input t_cp p11);
        write_base(REG_BYTE_BASE, bb);
        write_base(REG_WIDE_BASE, wb);
        write_base(REG_PAIR_00, p00);
        write_base(REG_PAIR_01, p01);
        write_base(REG_PAIR_10, p10);
        write_base(REG_PAIR_11, p11);
    endtask

    task automatic directed_checks();
        t_cp bb;
        t_cp wb;
        bit  s;
        bb = board.base[REG_BYTE_BASE];
        wb = board.base[REG_WIDE_BASE];
        push(board.base[REG_PAIR_00], 1'b0, 1'b0, s);
        push(t_cp'(board.base[REG_PAIR_00] + 4095), 1'b0, 1'b0, s);
        push(t_cp'(board.base[REG_PAIR_01] + 63), 1'b0, 1'b0, s);
        push(t_cp'(board.base[REG_PAIR_10] + 4032), 1'b0, 1'b0, s);
        push(t_cp'(board.base[REG_PAIR_11] + 4095), 1'b0, 1'b0, s);
        push(NEWLINE_CP, 1'b0, 1'b0, s);
        push(wb, 1'b0, 1'b0, s);
        push(t_cp'(wb + 4095), 1'b0, 1'b0, s);
        push(t_cp'(bb + 255), 1'b0, 1'b0, s);
        push(t_cp'(wb + 4095), 1'b0, 1'b0, s);
        push(bb, 1'b0, 1'b0, s);
        push(wb, 1'b0, 1'b0, s);
        push(bb, 1'b0, 1'b0, s);
        push(NEWLINE_CP, 1'b0, 1'b0, s);
        push(t_cp'(bb + 255), 1'b0, 1'b0, s);
        push(t_cp'(bb + 7), 1'b0, 1'b0, s);
        push(t_cp'($urandom), 1'b1, 1'b0, s);
    endtask

    task automatic end_stream();
        t_cp cp;
        bit  s;
        case ($urandom_range(0, 3))
            0: push(t_cp'($urandom), 1'b1, 1'b1, s);
            1: begin
                do cp = t_cp'($urandom); while (!board.would_halt(cp, 1'b0));
                push(cp, 1'b0, 1'b1, s);
            end
            2: begin
                push(board.base[REG_WIDE_BASE] + pick_offset(WIDE_SPAN), 1'b0, 1'b0, s);
                push(t_cp'($urandom), 1'b1, 1'b1, s);
            end
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    push(board.base[REG_BYTE_BASE] + pick_offset(BYTE_SPAN), 1'b0, 1'b0, s);
                end else begin
                    push(board.base[REG_WIDE_BASE] + pick_offset(WIDE_SPAN), 1'b0, 1'b0, s);
                end
                do cp = t_cp'($urandom); while (!board.would_halt(cp, 1'b0));
                push(cp, 1'b0, 1'b1, s);
            end
        endcase
        repeat (16) push(t_cp'($urandom), 1'($urandom_range(0, 1)), 1'b1, s);
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.code_point    <= '0;
        req_ch.end_of_stream <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        burst_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();
        run_phase(300);
        load_bases('0, '0, '0, '0, '0, '0);
        run_phase(60);
        load_bases(TOP_BASE, t_cp'(TOP_BASE - 4096), t_cp'(TOP_BASE - 20480),
                   t_cp'(TOP_BASE - 16384), t_cp'(TOP_BASE - 12288), t_cp'(TOP_BASE - 8192));
        run_phase(150);
        load_bases(t_cp'($urandom_range(0, 12288)), t_cp'($urandom_range(0, 12288)),
                   t_cp'($urandom_range(0, 12288)), t_cp'($urandom_range(0, 12288)),
                   t_cp'($urandom_range(0, 12288)), t_cp'($urandom_range(0, 12288)));
        run_phase(150);
        load_bases(RST_BYTE_BASE, RST_WIDE_BASE, RST_PAIR_00, RST_PAIR_01,
                   RST_PAIR_10, RST_PAIR_11);
        run_phase(130);
        end_stream();

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/cpbd_pkg.sv
design/cpbd_req_if.sv
design/cpbd_res_if.sv
design/cpbd_regs.sv
design/cpbd_front.sv
design/cpbd_queue.sv
design/cpbd_back.sv
design/codepoint_to_byte_decoder_core.sv
design/cpbd_checker.sv
tb/codepoint_to_byte_decoder_core_test.sv
